/* src/lhp_pkg.sv */
// shared types and constants for the latency histogram percentile monitor
`timescale 1ns / 1ps
package lhp_pkg;

  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned COUNT_W        = 32;
  localparam int unsigned SUM_W          = 56;
  localparam int unsigned PERMILLE_W     = 10;
  localparam int unsigned CHANNEL_W      = 2;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 10;
  localparam int unsigned PERMILLE_SCALE = 1000;
  localparam int unsigned TARGET_W       = COUNT_W + PERMILLE_W;
  localparam int unsigned PCT_N          = 3;

  localparam int unsigned BINS_DEFAULT         = 1024;
  localparam int unsigned CHANNELS_DEFAULT     = 4;
  localparam int unsigned BIN_WIDTH_US_DEFAULT = 40;

  localparam logic [PERMILLE_W-1:0] PCT_A_RESET = 10'd500;
  localparam logic [PERMILLE_W-1:0] PCT_B_RESET = 10'd950;
  localparam logic [PERMILLE_W-1:0] PCT_C_RESET = 10'd990;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_FLUSH = 1'b1
  } lhp_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED = 2'd0,
    CFG_PCT_A   = 2'd1,
    CFG_PCT_B   = 2'd2,
    CFG_PCT_C   = 2'd3
  } lhp_cfg_e;

  typedef struct packed {
    lhp_op_e               operation;
    logic [CHANNEL_W-1:0]  channel;
    logic [SAMPLE_W-1:0]   sample_us;
  } lhp_req_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]  report_channel;
    logic [COUNT_W-1:0]    sample_count;
    logic [SUM_W-1:0]      sample_sum;
    logic [SAMPLE_W-1:0]   max_sample;
    logic [SAMPLE_W-1:0]   pct_a_us;
    logic [SAMPLE_W-1:0]   pct_b_us;
    logic [SAMPLE_W-1:0]   pct_c_us;
  } lhp_rsp_t;

  // permille * (count - 1) for each reported percentile
  typedef struct packed {
    logic [TARGET_W-1:0] a;
    logic [TARGET_W-1:0] b;
    logic [TARGET_W-1:0] c;
  } lhp_targets_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] c;
  } lhp_pcts_t;

endpackage

/* src/latency_histogram_percentile_top.sv */
// top level of the latency histogram percentile monitor
`timescale 1ns / 1ps
// Per-channel latency monitor: add requests update count, sum and maximum at
// once and are accepted one per cycle outside a flush or the clearing pass; the
// histogram bin increment reaches the bin memory through the registers of the
// bin index divider, then a read-modify-write of the bin memory with forwarding.
// A flush request is held until pending bin updates have landed, then walks the
// channel's BINS bins one per cycle over the memory read port while zeroing
// them. Its report is registered once the walk has drained, later if the
// previous report has not yet been taken; no request is accepted from the flush
// until its report is registered. After reset a clearing pass zeroes the
// CHANNELS * BINS bins of the bin memory before the first request is taken;
// configuration writes are taken at any time.
module latency_histogram_percentile_top #(
  parameter int unsigned BINS         = lhp_pkg::BINS_DEFAULT,
  parameter int unsigned CHANNELS     = lhp_pkg::CHANNELS_DEFAULT,
  parameter int unsigned BIN_WIDTH_US = lhp_pkg::BIN_WIDTH_US_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lhp_pkg::lhp_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lhp_pkg::lhp_rsp_t              out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [lhp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lhp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lhp_pkg::*;

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned BIN_AW = $clog2(BINS);
  localparam int unsigned ADDR_W = CH_W + BIN_AW;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e st_q, st_d;
  logic [BIN_AW-1:0] bin_q, bin_d;
  logic [CH_W-1:0]   ch_q, ch_d;

  logic                  enabled_q;
  logic [PERMILLE_W-1:0] pct_a_q, pct_b_q, pct_c_q;

  logic [COUNT_W-1:0]  cnt_q [CHANNELS];
  logic [SUM_W-1:0]    sum_q [CHANNELS];
  logic [SAMPLE_W-1:0] max_q [CHANNELS];

  logic [CHANNEL_W-1:0] fl_ch_q;
  logic [COUNT_W-1:0]   fl_cnt_q;
  logic [SUM_W-1:0]     fl_sum_q;
  logic [SAMPLE_W-1:0]  fl_max_q;

  logic     out_valid_q;
  lhp_rsp_t out_q;

  logic [CH_W-1:0]     in_ch;
  logic                ch_ok, accept, do_add, do_flush, add_busy;
  logic [COUNT_W-1:0]  cnt_sel, cnt_inc, cnt_m1;
  logic [SUM_W-1:0]    sum_sel, sum_new;
  logic [SUM_W:0]      sum_ext;
  logic [SAMPLE_W-1:0] max_sel, max_new;
  lhp_targets_t        tgt;

  logic              idx_v, idx_busy, store_busy, walk_v, walk_done;
  logic [CH_W-1:0]   idx_ch;
  logic [BIN_AW-1:0] idx_bin;
  logic [COUNT_W-1:0] rd_data;
  logic              zero_we, walk_rd, out_load;
  lhp_pcts_t         pcts;

  always_comb begin
    in_ch    = CH_W'(in_req_i.channel);
    ch_ok    = int'(in_req_i.channel) < CHANNELS;
    add_busy = idx_busy | store_busy;
    // a flush waits for bin updates still on their way to the memory
    in_ready_o = (st_q == ST_RUN) && !((in_req_i.operation == OP_FLUSH) && add_busy);
    accept   = in_valid_i & in_ready_o;
    do_add   = accept && (in_req_i.operation == OP_ADD) && enabled_q && ch_ok;
    do_flush = accept && (in_req_i.operation == OP_FLUSH) && ch_ok;

    cnt_sel = cnt_q[in_ch];
    sum_sel = sum_q[in_ch];
    max_sel = max_q[in_ch];
    cnt_inc = (&cnt_sel) ? cnt_sel : cnt_sel + COUNT_W'(1);
    sum_ext = {1'b0, sum_sel} + (SUM_W + 1)'(in_req_i.sample_us);
    sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    max_new = (in_req_i.sample_us > max_sel) ? in_req_i.sample_us : max_sel;
    cnt_m1  = cnt_sel - COUNT_W'(1);
    tgt.a   = TARGET_W'(pct_a_q) * TARGET_W'(cnt_m1);
    tgt.b   = TARGET_W'(pct_b_q) * TARGET_W'(cnt_m1);
    tgt.c   = TARGET_W'(pct_c_q) * TARGET_W'(cnt_m1);
  end

  always_comb begin
    st_d     = st_q;
    bin_d    = bin_q;
    ch_d     = ch_q;
    zero_we  = 1'b0;
    walk_rd  = 1'b0;
    out_load = 1'b0;
    unique case (st_q)
      ST_CLEAR: begin
        zero_we = 1'b1;
        bin_d   = bin_q + BIN_AW'(1);
        if (bin_q == BIN_AW'(BINS - 1)) begin
          bin_d = '0;
          ch_d  = ch_q + CH_W'(1);
          if (ch_q == CH_W'(CHANNELS - 1)) begin
            ch_d = '0;
            st_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (do_flush) begin
          ch_d  = in_ch;
          bin_d = '0;
          st_d  = ST_WALK;
        end
      end
      ST_WALK: begin
        zero_we = 1'b1;
        walk_rd = 1'b1;
        bin_d   = bin_q + BIN_AW'(1);
        if (bin_q == BIN_AW'(BINS - 1)) begin
          bin_d = '0;
          st_d  = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (walk_done) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          st_d     = ST_RUN;
        end
      end
      default: begin
        st_d  = ST_CLEAR;
        bin_d = '0;
        ch_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      bin_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      bin_q       <= bin_d;
      ch_q        <= ch_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      pct_a_q   <= PCT_A_RESET;
      pct_b_q   <= PCT_B_RESET;
      pct_c_q   <= PCT_C_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLED: enabled_q <= cfg_data_i[0];
        CFG_PCT_A:   pct_a_q   <= cfg_data_i;
        CFG_PCT_B:   pct_b_q   <= cfg_data_i;
        CFG_PCT_C:   pct_c_q   <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_q[c] <= '0;
        sum_q[c] <= '0;
        max_q[c] <= '0;
      end
    end else if (do_add) begin
      cnt_q[in_ch] <= cnt_inc;
      sum_q[in_ch] <= sum_new;
      max_q[in_ch] <= max_new;
    end else if (do_flush) begin
      cnt_q[in_ch] <= '0;
      sum_q[in_ch] <= '0;
      max_q[in_ch] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_flush) begin
      fl_ch_q  <= in_req_i.channel;
      fl_cnt_q <= cnt_sel;
      fl_sum_q <= sum_sel;
      fl_max_q <= max_sel;
    end
    if (out_load) begin
      out_q.report_channel <= fl_ch_q;
      out_q.sample_count   <= fl_cnt_q;
      out_q.sample_sum     <= fl_sum_q;
      out_q.max_sample     <= fl_max_q;
      out_q.pct_a_us       <= pcts.a;
      out_q.pct_b_us       <= pcts.b;
      out_q.pct_c_us       <= pcts.c;
    end
  end

  lhp_bin_index #(
    .BINS         (BINS),
    .BIN_WIDTH_US (BIN_WIDTH_US),
    .CH_W         (CH_W)
  ) u_bin_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (do_add),
    .sample_i    (in_req_i.sample_us),
    .ch_i        (in_ch),
    .out_valid_o (idx_v),
    .out_ch_o    (idx_ch),
    .out_bin_o   (idx_bin),
    .busy_o      (idx_busy)
  );

  lhp_bin_store #(
    .ADDR_W (ADDR_W)
  ) u_bin_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .add_valid_i  (idx_v),
    .add_addr_i   ({idx_ch, idx_bin}),
    .zero_we_i    (zero_we),
    .zero_addr_i  ({ch_q, bin_q}),
    .walk_rd_i    (walk_rd),
    .walk_valid_o (walk_v),
    .rd_data_o    (rd_data),
    .busy_o       (store_busy)
  );

  lhp_pct_walk #(
    .BINS         (BINS),
    .BIN_WIDTH_US (BIN_WIDTH_US)
  ) u_pct_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (do_flush),
    .tgt_i        (tgt),
    .empty_i      (cnt_sel == '0),
    .max_i        (max_sel),
    .data_valid_i (walk_v),
    .data_i       (rd_data),
    .done_o       (walk_done),
    .pct_o        (pcts)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* src/lhp_bin_index.sv */
// two-stage pipeline mapping a sample to its clamped histogram bin
`timescale 1ns / 1ps
module lhp_bin_index #(
  parameter int unsigned BINS         = lhp_pkg::BINS_DEFAULT,
  parameter int unsigned BIN_WIDTH_US = lhp_pkg::BIN_WIDTH_US_DEFAULT,
  parameter int unsigned CH_W         = $clog2(lhp_pkg::CHANNELS_DEFAULT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [lhp_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [CH_W-1:0]               ch_i,
  output logic                          out_valid_o,
  output logic [CH_W-1:0]               out_ch_o,
  output logic [$clog2(BINS)-1:0]       out_bin_o,
  output logic                          busy_o
);
  import lhp_pkg::*;

  localparam int unsigned BIN_AW  = $clog2(BINS);
  localparam int unsigned RECIP_W = SAMPLE_W + 1;
  localparam int unsigned PROD_W  = SAMPLE_W + RECIP_W;
  localparam int unsigned W_W     = $clog2(BIN_WIDTH_US + 1);
  localparam int unsigned REM_W   = SAMPLE_W + W_W;
  localparam int unsigned Q_W     = SAMPLE_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SAMPLE_W) / BIN_WIDTH_US);

  logic                  v1_q, v2_q;
  logic [PROD_W-1:0]     prod_q;
  logic [SAMPLE_W-1:0]   s1_q;
  logic [CH_W-1:0]       ch1_q, ch2_q;
  logic [BIN_AW-1:0]     bin_q, bin_d;

  logic [Q_W-1:0]        q_est, q_fix;
  logic [REM_W-1:0]      qw, rem;

  // estimate is exact or one low, one compare fixes it
  always_comb begin
    q_est = prod_q[PROD_W-1:SAMPLE_W];
    qw    = REM_W'(q_est) * REM_W'(BIN_WIDTH_US);
    rem   = REM_W'(s1_q) - qw;
    q_fix = (rem >= REM_W'(BIN_WIDTH_US)) ? q_est + Q_W'(1) : q_est;
    if (q_fix > Q_W'(BINS - 1)) begin
      bin_d = BIN_AW'(BINS - 1);
    end else begin
      bin_d = q_fix[BIN_AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      prod_q <= PROD_W'(sample_i) * PROD_W'(RECIP);
      s1_q   <= sample_i;
      ch1_q  <= ch_i;
    end
    if (v1_q) begin
      bin_q <= bin_d;
      ch2_q <= ch1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_ch_o    = ch2_q;
  assign out_bin_o   = bin_q;
  assign busy_o      = v1_q | v2_q;

endmodule

/* src/lhp_bin_store.sv */
// bin count memory with read-modify-write increment and zeroing port
`timescale 1ns / 1ps
module lhp_bin_store #(
  parameter int unsigned ADDR_W = $clog2(lhp_pkg::BINS_DEFAULT) +
                                  $clog2(lhp_pkg::CHANNELS_DEFAULT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          add_valid_i,
  input  logic [ADDR_W-1:0]             add_addr_i,
  input  logic                          zero_we_i,
  input  logic [ADDR_W-1:0]             zero_addr_i,
  input  logic                          walk_rd_i,
  output logic                          walk_valid_o,
  output logic [lhp_pkg::COUNT_W-1:0]   rd_data_o,
  output logic                          busy_o
);
  import lhp_pkg::*;

  logic [COUNT_W-1:0] mem_q [2**ADDR_W];
  logic [COUNT_W-1:0] rd_data_q;

  logic               a_v_q;
  logic [ADDR_W-1:0]  a_addr_q;
  logic               walk_v_q;
  logic               fw_v_q;
  logic [ADDR_W-1:0]  fw_addr_q;
  logic [COUNT_W-1:0] fw_data_q;

  logic               rd_en, we;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [COUNT_W-1:0] cur, inc, wr_data;

  always_comb begin
    // back-to-back hits on one bin take the value written last cycle
    cur     = (fw_v_q && (fw_addr_q == a_addr_q)) ? fw_data_q : rd_data_q;
    inc     = (&cur) ? cur : cur + COUNT_W'(1);
    rd_en   = walk_rd_i | add_valid_i;
    rd_addr = walk_rd_i ? zero_addr_i : add_addr_i;
    we      = zero_we_i | a_v_q;
    wr_addr = zero_we_i ? zero_addr_i : a_addr_q;
    wr_data = zero_we_i ? '0 : inc;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q    <= 1'b0;
      walk_v_q <= 1'b0;
      fw_v_q   <= 1'b0;
    end else begin
      a_v_q    <= add_valid_i & ~walk_rd_i;
      walk_v_q <= walk_rd_i;
      fw_v_q   <= a_v_q & ~zero_we_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_valid_i) begin
      a_addr_q <= add_addr_i;
    end
    if (a_v_q) begin
      fw_addr_q <= a_addr_q;
      fw_data_q <= inc;
    end
  end

  assign walk_valid_o = walk_v_q;
  assign rd_data_o    = rd_data_q;
  assign busy_o       = a_v_q;

endmodule

/* src/lhp_pct_walk.sv */
// running-total walker that picks the three percentile bins
`timescale 1ns / 1ps
module lhp_pct_walk #(
  parameter int unsigned BINS         = lhp_pkg::BINS_DEFAULT,
  parameter int unsigned BIN_WIDTH_US = lhp_pkg::BIN_WIDTH_US_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  lhp_pkg::lhp_targets_t         tgt_i,
  input  logic                          empty_i,
  input  logic [lhp_pkg::SAMPLE_W-1:0]  max_i,
  input  logic                          data_valid_i,
  input  logic [lhp_pkg::COUNT_W-1:0]   data_i,
  output logic                          done_o,
  output lhp_pkg::lhp_pcts_t            pct_o
);
  import lhp_pkg::*;

  localparam int unsigned BIN_AW = $clog2(BINS);
  localparam int unsigned ACC_W  = TARGET_W + BIN_AW;
  localparam int unsigned HALF   = BIN_WIDTH_US / 2;

  logic [BIN_AW-1:0]   idx_q, idx1_q;
  logic                v1_q, done_q;
  logic [TARGET_W-1:0] scaled_q;
  logic [ACC_W-1:0]    acc_q, acc_sum;
  logic [PCT_N-1:0]    found_q;
  logic [BIN_AW-1:0]   pick_q [PCT_N];
  lhp_targets_t        tgt_q;
  logic                empty_q;
  logic [SAMPLE_W-1:0] max_q;

  logic [TARGET_W-1:0] tgt_arr [PCT_N];
  logic [SAMPLE_W-1:0] res [PCT_N];

  // running total times 1000 beats permille*(count-1) exactly when the
  // total reaches floor(permille*(count-1)/1000)+1
  always_comb begin
    tgt_arr[0] = tgt_q.a;
    tgt_arr[1] = tgt_q.b;
    tgt_arr[2] = tgt_q.c;
    acc_sum    = acc_q + ACC_W'(scaled_q);
    for (int k = 0; k < PCT_N; k++) begin
      if (empty_q) begin
        res[k] = '0;
      end else if (found_q[k]) begin
        res[k] = SAMPLE_W'(SAMPLE_W'(pick_q[k]) * SAMPLE_W'(BIN_WIDTH_US) + SAMPLE_W'(HALF));
      end else begin
        res[k] = max_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      found_q <= '0;
      acc_q   <= '0;
    end else begin
      v1_q   <= data_valid_i;
      done_q <= v1_q && (idx1_q == BIN_AW'(BINS - 1));
      if (start_i) begin
        idx_q   <= '0;
        found_q <= '0;
        acc_q   <= '0;
      end else begin
        if (data_valid_i) begin
          idx_q <= idx_q + BIN_AW'(1);
        end
        if (v1_q) begin
          acc_q <= acc_sum;
          for (int k = 0; k < PCT_N; k++) begin
            if (!found_q[k] && (acc_sum > ACC_W'(tgt_arr[k]))) begin
              found_q[k] <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      tgt_q   <= tgt_i;
      empty_q <= empty_i;
      max_q   <= max_i;
    end
    if (data_valid_i) begin
      idx1_q   <= idx_q;
      scaled_q <= TARGET_W'(data_i) * TARGET_W'(PERMILLE_SCALE);
    end
    if (v1_q) begin
      for (int k = 0; k < PCT_N; k++) begin
        if (!found_q[k] && (acc_sum > ACC_W'(tgt_arr[k]))) begin
          pick_q[k] <= idx1_q;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign pct_o.a = res[0];
  assign pct_o.b = res[1];
  assign pct_o.c = res[2];

endmodule
